@@ sv/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Request and status codes, payload widths, controller state and command.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WIDTH_DEF = 32;

	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int FILL_W   = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_READ       = 3'd4,
		OP_WRITE      = 3'd5
	} dq_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} dq_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} dq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the incoming request
		logic exec;   // carry out the captured request
	} dq_cmd_t;

endpackage

@@ sv/dq_if.sv @@
// ----------------------------------------------------------------------------
// dq_req_if / dq_rsp_if: request and response channels
// Valid/ready channels carrying one request or one response per transaction.
// ----------------------------------------------------------------------------
interface dq_req_if;
	import dq_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [VALUE_W-1:0]  value;
	logic [POS_W-1:0]    position;

	modport source (output valid, output func, output value, output position, input ready);
	modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface dq_rsp_if;
	import dq_pkg::*;

	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  read_value;
	logic [FILL_W-1:0]   fill;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output read_value, output fill, output status, input ready);
	modport sink   (input valid, input read_value, input fill, input status, output ready);
endinterface

@@ sv/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue: fixed-capacity double-ended queue on a ring buffer
// Push and pop at either end, plus indexed read and write, one response per
// request.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Payload
//  -------  ---  ------------  ---------------------------------------
//  req      in   valid/ready   func[2:0], value[31:0], position[3:0]
//  rsp      out  valid/ready   read_value[31:0], fill[4:0], status[1:0]
//
// A request transaction is captured at the accepting edge, executed in the
// next cycle, and its response is presented from the cycle after that. The
// request capture register and the registered read of the element memory
// set this sequence, so a new request is not taken while one is executing.
// A stalled response holds steady, and the next request is accepted in the
// cycle its predecessor's response is taken. Reset clears the head pointer
// and the element count at once; the element memory itself is not cleared.
//
module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF,
	parameter int WIDTH = dq_pkg::WIDTH_DEF
) (
	input logic     clk,
	input logic     arst_n,
	dq_req_if.sink  req,
	dq_rsp_if.source rsp
);
	import dq_pkg::*;

	// Command bundle from the sequencer to the datapath.
	dq_cmd_t cmd;

	// The sequencer owns both handshakes and steps each request through
	// capture, execute and hand-off.
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// The datapath holds the ring: memory, head pointer and count. Pushes
	// and pops at the front only move the head pointer; nothing is shifted.
	// The response registers it keeps stay stable while the response stalls.
	dq_datapath #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (req.func),
		.value      (req.value),
		.position   (req.position),
		.read_value (rsp.read_value),
		.fill       (rsp.fill),
		.status     (rsp.status)
	);

endmodule

@@ sv/dq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dq_ctrl: request sequencer of the double-ended queue
// Runs each request through capture, execute and response hand-off.
// ----------------------------------------------------------------------------
module dq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output dq_pkg::dq_cmd_t cmd
);
	import dq_pkg::*;

	dq_state_t state_q;
	dq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				// A new request may enter in the cycle the response leaves.
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
				cmd.load  = rsp_ready & req_valid;
				if (rsp_ready) begin
					state_d = req_valid ? S_EXEC : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ sv/dq_datapath.sv @@
// ----------------------------------------------------------------------------
// dq_datapath: ring storage and pointers of the double-ended queue
// Holds the element memory, head pointer, element count and result registers.
// ----------------------------------------------------------------------------
module dq_datapath #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF,
	parameter int WIDTH = dq_pkg::WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dq_pkg::dq_cmd_t               cmd,
	input  logic [dq_pkg::FUNC_W-1:0]     func,
	input  logic [dq_pkg::VALUE_W-1:0]    value,
	input  logic [dq_pkg::POS_W-1:0]      position,
	output logic [dq_pkg::VALUE_W-1:0]    read_value,
	output logic [dq_pkg::FILL_W-1:0]     fill,
	output logic [dq_pkg::STATUS_W-1:0]   status
);
	import dq_pkg::*;

	localparam int PW   = $clog2(DEPTH);
	localparam int SW   = PW + 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	// Captured request.
	logic [FUNC_W-1:0]   func_q;
	logic [WIDTH-1:0]    value_q;
	logic [POS_W-1:0]    pos_q;

	// Queue state.
	logic [PW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [WIDTH-1:0]    mem_q [DEPTH];

	// Result.
	logic [WIDTH-1:0]    rdata_q;
	logic                rd_en_q;
	logic [STATUS_W-1:0] status_q;

	logic [PW-1:0]       head_d;
	logic [CW-1:0]       count_d;
	logic [STATUS_W-1:0] status_d;
	logic                rd_en_d;
	logic                wr_en;
	logic [PW-1:0]       wr_slot;
	logic [PW-1:0]       back_slot;
	logic [PW-1:0]       pos_slot;
	logic [PW-1:0]       next_slot;
	logic [PW-1:0]       prev_slot;
	logic                full;
	logic                empty;
	logic                out_of_range;

	// Folds head plus offset back into the ring; the sum is below twice DEPTH.
	function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
		wrap = (s >= SW'(DEPTH)) ? PW'(s - SW'(DEPTH)) : PW'(s);
	endfunction

	assign full         = (count_q == CW'(DEPTH));
	assign empty        = (count_q == '0);
	assign out_of_range = (CMPW'(pos_q) >= CMPW'(count_q));
	assign back_slot    = wrap(SW'(head_q) + SW'(count_q));
	assign pos_slot     = wrap(SW'(head_q) + SW'(pos_q));
	assign next_slot    = wrap(SW'(head_q) + SW'(1));
	assign prev_slot    = (head_q == '0) ? PW'(DEPTH - 1) : head_q - PW'(1);

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = ST_OK;
		rd_en_d  = 1'b0;
		wr_en    = 1'b0;
		wr_slot  = pos_slot;
		unique case (func_q)
			OP_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_slot = back_slot;
					count_d = count_q + CW'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_slot = prev_slot;
					head_d  = prev_slot;
					count_d = count_q + CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					head_d  = next_slot;
					count_d = count_q - CW'(1);
				end
			end
			OP_READ: begin
				if (out_of_range) begin
					status_d = ST_RANGE;
				end else begin
					rd_en_d = 1'b1;
				end
			end
			OP_WRITE: begin
				if (out_of_range) begin
					status_d = ST_RANGE;
				end else begin
					wr_en = 1'b1;
				end
			end
			default: begin
				// Unused codes leave the queue alone and report ok.
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			value_q <= WIDTH'(value);
			pos_q   <= position;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			rdata_q  <= mem_q[pos_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem_q[wr_slot] <= value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rd_en_q <= 1'b0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
			rd_en_q <= rd_en_d;
		end
	end

	assign read_value = rd_en_q ? VALUE_W'(rdata_q) : '0;
	assign fill       = FILL_W'(count_q);
	assign status     = status_q;

endmodule

@@ sv/dq_checker.sv @@
// ----------------------------------------------------------------------------
// dq_checker: port-level checks of the double-ended queue
// Watches the response channel: stall hold, fill bound, and consistency of fill, status and read data.
// ----------------------------------------------------------------------------
module dq_checker #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [dq_pkg::VALUE_W-1:0]    rsp_read_value,
	input logic [dq_pkg::FILL_W-1:0]     rsp_fill,
	input logic [dq_pkg::STATUS_W-1:0]   rsp_status
);
	import dq_pkg::*;

	// A response that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response withdrawn while stalled");

	// The fill never exceeds the capacity.
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp_fill) <= DEPTH) || (DEPTH >= 32))
		else $error("fill exceeds capacity");

	// A dropped push only happens on a full queue.
	a_full_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_fill == FILL_W'(DEPTH))
		else $error("full reported while not full");

	// An ignored pop only happens on an empty queue.
	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_fill == '0)
		else $error("empty reported while not empty");

	// Read data only comes with a successful request.
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_read_value != '0 |-> rsp_status == ST_OK)
		else $error("read data returned with an error status");

endmodule

bind double_ended_queue dq_checker #(
	.DEPTH (DEPTH)
) u_dq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value),
	.rsp_fill       (rsp.fill),
	.rsp_status     (rsp.status)
);

@@ sim/dq_response_checker.sv @@
// ----------------------------------------------------------------------------
// dq_response_checker: response prediction and comparison for the deque
// Watches both channels, keeps its own ring, head and count, and compares
// every response with the oldest predicted one.
// ----------------------------------------------------------------------------
module dq_response_checker (
	input  logic        clk,
	input  logic        arst_n,
	dq_req_if           req,
	dq_rsp_if           rsp,
	output int          mismatch_count,
	output int          pending,
	output logic [4:0]  model_fill
);
	import dq_pkg::*;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [FILL_W-1:0]  fill;
		dq_status_t         status;
	} dq_result_t;

	logic [VALUE_W-1:0] ring_store [DEPTH_DEF];
	logic [POS_W-1:0]   ring_head;
	logic [FILL_W-1:0]  ring_count;
	dq_result_t         awaited_results [$];

	// Carries out one request on the shadow ring and returns its response.
	function automatic dq_result_t apply_request(logic [FUNC_W-1:0] func,
			logic [VALUE_W-1:0] value, logic [POS_W-1:0] position);
		dq_result_t res;
		res.read_value = '0;
		res.status     = ST_OK;
		case (func)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (ring_count >= DEPTH_DEF) begin
					res.status = ST_FULL;
				end else if (func == OP_PUSH_BACK) begin
					ring_store[ring_head + ring_count[POS_W-1:0]] = value;
					ring_count = ring_count + 1'b1;
				end else begin
					ring_head = ring_head - 1'b1;
					ring_store[ring_head] = value;
					ring_count = ring_count + 1'b1;
				end
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				if (ring_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					if (func == OP_POP_FRONT)
						ring_head = ring_head + 1'b1;
					ring_count = ring_count - 1'b1;
				end
			end
			OP_READ: begin
				if (position >= ring_count)
					res.status = ST_RANGE;
				else
					res.read_value = ring_store[ring_head + position];
			end
			OP_WRITE: begin
				if (position >= ring_count)
					res.status = ST_RANGE;
				else
					ring_store[ring_head + position] = value;
			end
			default: begin
			end
		endcase
		res.fill = ring_count;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dq_result_t want;
		if (!arst_n) begin
			ring_head      = '0;
			ring_count     = '0;
			mismatch_count = 0;
			awaited_results.delete();
		end else begin
			// A response always belongs to an earlier request, so it is
			// checked before a request taken at the same edge is predicted.
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: response with none expected: value %h fill %0d status %0d",
						$time, rsp.read_value, rsp.fill, rsp.status);
				end else begin
					want = awaited_results[0];
					awaited_results.delete(0);
					if (rsp.read_value !== want.read_value) begin
						mismatch_count++;
						$display("%0t: read_value expected %h actual %h",
							$time, want.read_value, rsp.read_value);
					end
					if (rsp.fill !== want.fill) begin
						mismatch_count++;
						$display("%0t: fill expected %0d actual %0d",
							$time, want.fill, rsp.fill);
					end
					if (rsp.status !== want.status) begin
						mismatch_count++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
					end
				end
			end
			if (req.valid && req.ready)
				awaited_results = {awaited_results,
					apply_request(req.func, req.value, req.position)};
		end
		pending    = awaited_results.size();
		model_fill = ring_count;
	end

endmodule

@@ sim/tb_double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// tb_double_ended_queue: stimulus and verdict for the double-ended queue
// Drives directed and random request transactions with random gaps and
// response stalls; a separate checker predicts and compares the responses.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
	import dq_pkg::*;

	// Request codes that the block must treat as no operation.
	localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

	// Shapes of the random stream: mostly pushes, mostly pops, or even.
	localparam int MODE_GROW   = 0;
	localparam int MODE_SHRINK = 1;
	localparam int MODE_MIXED  = 2;

	localparam int RANDOM_ITEMS = 900;
	localparam int HOLD_AT      = 300;   // when the long response stall starts
	localparam int HOLD_CYCLES  = 60;
	localparam int STEADY_FROM  = 420;   // window with no idling on either side
	localparam int STEADY_TO    = 580;
	localparam int DRAIN_AT     = 680;   // sender waits for every response here
	localparam int CYCLE_LIMIT  = 200000;

	logic       clk;
	logic       arst_n;
	int         mismatch_count;
	int         pending;
	logic [4:0] model_fill;
	int         items_sent;
	int         cycles;
	bit         steady;
	bit         hold_done;

	dq_req_if req_ch ();
	dq_rsp_if rsp_ch ();

	double_ended_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	dq_response_checker checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.pending        (pending),
		.model_fill     (model_fill)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Every input is known from time zero; reset is held low at the start and
	// released on a falling edge, and it is never asserted again.
	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.func     = '0;
		req_ch.value    = '0;
		req_ch.position = '0;
		rsp_ch.ready    = 1'b0;
		items_sent      = 0;
		steady          = 1'b0;
		hold_done       = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// A run that never drains its expected responses ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offers one request transaction, possibly after random idle cycles, and
	// returns on the falling edge after it was accepted. Valid stays high
	// across back-to-back transactions, so it is written once per edge.
	task automatic send_item(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value,
			input logic [POS_W-1:0] position);
		while (!steady && $urandom_range(99) < 22) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.func     <= func;
		req_ch.value    <= value;
		req_ch.position <= position;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Chooses a request code for the random stream. Pushes win while the
	// queue grows and pops while it shrinks, so both the full and the empty
	// corner are visited again and again; spare codes show up now and then.
	function automatic logic [FUNC_W-1:0] pick_func(int mode);
		int roll;
		int push_cut;
		int pop_cut;
		roll     = $urandom_range(99);
		push_cut = (mode == MODE_GROW) ? 55 : (mode == MODE_SHRINK) ? 20 : 35;
		pop_cut  = push_cut + ((mode == MODE_SHRINK) ? 45 : (mode == MODE_GROW) ? 15 : 30);
		if (roll < push_cut)
			return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		else if (roll < pop_cut)
			return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
		else if (roll < 97)
			return $urandom_range(1) ? OP_READ : OP_WRITE;
		else
			return $urandom_range(1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
	endfunction

	// Element values lean on the two extremes besides plain random words.
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Positions mostly land on live elements; the rest may run past the count.
	function automatic logic [POS_W-1:0] pick_position(logic [4:0] fill);
		if (fill != 0 && $urandom_range(9) < 8)
			return POS_W'($urandom_range(fill - 1));
		return POS_W'($urandom_range(15));
	endfunction

	// Response side: random stalls, a steady window, and one long hold-off
	// while the sender keeps offering so that the request side backs up.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 22);
			end
		end
	end

	initial begin
		int mode;
		@(posedge arst_n);
		@(negedge clk);

		// Directed part: pops and indexed access on an empty queue, a push
		// at the front that wraps the head pointer below slot zero, reads
		// across that wrap, an indexed write, the spare codes, and draining
		// back to empty with one more pop on the empty queue.
		send_item(OP_POP_BACK, '0, '0);
		send_item(OP_POP_FRONT, '0, '0);
		send_item(OP_READ, '0, '0);
		send_item(OP_WRITE, 32'h0BAD_F00D, '0);
		send_item(OP_PUSH_FRONT, '1, '0);
		send_item(OP_PUSH_BACK, '0, '1);
		send_item(OP_PUSH_FRONT, 32'h1234_5678, '0);
		send_item(OP_READ, '0, 4'd0);
		send_item(OP_READ, '0, 4'd1);
		send_item(OP_READ, '0, 4'd2);
		send_item(OP_READ, '0, 4'd3);
		send_item(OP_WRITE, 32'hA5A5_A5A5, 4'd2);
		send_item(OP_READ, '0, 4'd2);
		send_item(OP_READ, '0, 4'd15);
		send_item(FUNC_SPARE_6, '1, 4'd0);
		send_item(FUNC_SPARE_7, '1, 4'd1);
		send_item(OP_POP_FRONT, '0, '0);
		send_item(OP_POP_BACK, '0, '0);
		send_item(OP_READ, '0, 4'd0);
		send_item(OP_POP_FRONT, '0, '0);
		send_item(OP_POP_BACK, '0, '0);
		send_item(OP_WRITE, '1, 4'd15);

		// Random part. The stream picks its shape at random every forty requests,
		// which walks the fill level from empty to full and back many times.
		mode = MODE_GROW;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				mode = $urandom_range(MODE_MIXED);
			steady = (n >= STEADY_FROM && n < STEADY_TO);
			if (n == DRAIN_AT) begin
				// Pause the request side until every response has come back.
				req_ch.valid <= 1'b0;
				do @(negedge clk); while (pending != 0);
			end
			send_item(pick_func(mode), pick_value(), pick_position(model_fill));
		end
		steady = 1'b0;
		req_ch.valid <= 1'b0;

		// Let the last responses come out, then keep the bench quiet so that a stray
		// extra response would still be caught.
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ files.f @@
sv/dq_pkg.sv
sv/dq_if.sv
sv/dq_ctrl.sv
sv/dq_datapath.sv
sv/double_ended_queue.sv
sv/dq_checker.sv
sim/dq_response_checker.sv
sim/tb_double_ended_queue.sv
